@@ hdl/symcrc_pkg.sv @@
// shared types, constants and crc helpers for the symbol crc32c engine
`default_nettype none

package symcrc_pkg;

  localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
  localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
  localparam int unsigned HDR_BYTES    = 14;
  localparam int unsigned HDR_BITS     = HDR_BYTES * 8;
  localparam logic [15:0] MAX_LEN_RST  = 16'd1024;

  localparam int unsigned IN_DATA_W    = 152;
  localparam int unsigned IN_USER_W    = 2;
  localparam int unsigned OUT_DATA_W   = 40;

  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  // input item kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_HDR     = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_RAW     = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  // work orders for the back end
  typedef enum logic [2:0] {
    CMD_HDR_OPEN  = 3'd0,
    CMD_HDR_DONE  = 3'd1,
    CMD_SYM_BYTE  = 3'd2,
    CMD_RAW_START = 3'd3,
    CMD_RAW_BYTE  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    RUN_IDLE = 3'b001,
    RUN_SYM  = 3'b010,
    RUN_RAW  = 3'b100
  } run_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        emit;
    logic [31:0] crc;
    logic [31:0] exp_crc;
    logic [7:0]  data;
  } entry_t;

  // n reflected shift steps with zero data, for elaboration-time constants
  function automatic logic [31:0] crc_steps(input logic [31:0] c, input int n);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < n; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // absorb one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/symcrc_front.sv @@
// front end: accepts items, tracks the open run and computes header crcs
`default_nettype none

module symcrc_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [15:0]                         cfg_wr_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [symcrc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [symcrc_pkg::IN_USER_W-1:0]    in_tuser,
  input  wire logic                                in_tlast,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output symcrc_pkg::entry_t                       q_entry
);

  logic [31:0]  pkt_id;
  logic [31:0]  fec_id;
  logic [15:0]  sym_idx;
  logic [15:0]  sym_cnt;
  logic [15:0]  pay_len;
  logic [31:0]  stored_crc;
  logic [7:0]   data_byte;

  assign pkt_id     = in_tdata[31:0];
  assign fec_id     = in_tdata[63:32];
  assign sym_idx    = in_tdata[79:64];
  assign sym_cnt    = in_tdata[95:80];
  assign pay_len    = in_tdata[111:96];
  assign stored_crc = in_tdata[143:112];
  assign data_byte  = in_tdata[151:144];

  logic [symcrc_pkg::HDR_BITS-1:0] hdr_be;
  assign hdr_be = {pkt_id, fec_id, sym_idx, sym_cnt, pay_len};

  // crc is linear: seed term plus one constant column per header bit
  localparam logic [31:0] SEED_TERM =
    symcrc_pkg::crc_steps(symcrc_pkg::CRC_ONES, symcrc_pkg::HDR_BITS);

  logic [31:0] term [symcrc_pkg::HDR_BITS];

  for (genvar b = 0; b < symcrc_pkg::HDR_BYTES; b++) begin : g_byte
    for (genvar j = 0; j < 8; j++) begin : g_bit
      localparam logic [31:0] COL =
        symcrc_pkg::crc_steps(32'(1) << j, 8 * (symcrc_pkg::HDR_BYTES - b));
      assign term[8*b+j] = hdr_be[symcrc_pkg::HDR_BITS - 8 - 8*b + j] ? COL : '0;
    end
  end

  logic [31:0] hdr_crc;
  always_comb begin
    hdr_crc = SEED_TERM;
    for (int i = 0; i < symcrc_pkg::HDR_BITS; i++) begin
      hdr_crc = hdr_crc ^ term[i];
    end
  end

  symcrc_pkg::run_t run_r, run_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [15:0]      max_len_r;
  logic             accept;
  logic             in_range;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign in_range  = (pay_len != 16'd0) && (pay_len <= max_len_r);

  always_comb begin
    run_nxt         = run_r;
    rem_nxt         = rem_r;
    q_push          = 1'b0;
    q_entry.cmd     = symcrc_pkg::CMD_HDR_DONE;
    q_entry.emit    = 1'b0;
    q_entry.crc     = hdr_crc;
    q_entry.exp_crc = stored_crc;
    q_entry.data    = data_byte;
    if (accept) begin
      unique case (symcrc_pkg::opcode_t'(in_tuser))
        symcrc_pkg::OP_HDR: begin
          q_push       = 1'b1;
          q_entry.cmd  = in_range ? symcrc_pkg::CMD_HDR_OPEN : symcrc_pkg::CMD_HDR_DONE;
          q_entry.emit = !in_range;
          run_nxt      = in_range ? symcrc_pkg::RUN_SYM : symcrc_pkg::RUN_IDLE;
          rem_nxt      = in_range ? pay_len : 16'd0;
        end
        symcrc_pkg::OP_PAYLOAD: begin
          // payload with no open symbol is dropped here
          if (run_r == symcrc_pkg::RUN_SYM) begin
            q_push       = 1'b1;
            q_entry.cmd  = symcrc_pkg::CMD_SYM_BYTE;
            q_entry.emit = (rem_r == 16'd1);
            rem_nxt      = rem_r - 16'd1;
            if (rem_r == 16'd1) begin
              run_nxt = symcrc_pkg::RUN_IDLE;
            end
          end
        end
        symcrc_pkg::OP_RAW: begin
          q_push       = 1'b1;
          q_entry.cmd  = (run_r == symcrc_pkg::RUN_RAW) ? symcrc_pkg::CMD_RAW_BYTE
                                                        : symcrc_pkg::CMD_RAW_START;
          q_entry.emit = in_tlast;
          run_nxt      = in_tlast ? symcrc_pkg::RUN_IDLE : symcrc_pkg::RUN_RAW;
          rem_nxt      = 16'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= symcrc_pkg::RUN_IDLE;
      rem_r     <= '0;
      max_len_r <= symcrc_pkg::MAX_LEN_RST;
    end else begin
      run_r <= run_nxt;
      rem_r <= rem_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/symcrc_fifo.sv @@
// short command queue between front and back end
`default_nettype none

module symcrc_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire symcrc_pkg::entry_t  wr_entry,
  input  wire logic                pop,
  output symcrc_pkg::entry_t       rd_entry,
  output logic                     full,
  output logic                     empty
);

  symcrc_pkg::entry_t              mem_r [symcrc_pkg::FIFO_DEPTH];
  logic [symcrc_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [symcrc_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [symcrc_pkg::FIFO_AW:0]    count_r;
  logic                            do_push;
  logic                            do_pop;

  assign full     = (count_r == (symcrc_pkg::FIFO_AW+1)'(symcrc_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/symcrc_back.sv @@
// back end: byte crc accumulator and result output register
`default_nettype none

module symcrc_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire symcrc_pkg::entry_t                  q_entry,
  input  wire logic                                q_empty,
  output logic                                     q_pop,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [symcrc_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                     out_tuser
);

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic        valid_r;
  logic [31:0] res_crc_r, res_crc_nxt;
  logic        res_match_r, res_match_nxt;
  logic        res_kind_r, res_kind_nxt;
  logic [31:0] base;
  logic [31:0] absorbed;
  logic        out_free;

  assign out_free = !valid_r || out_tready;
  assign q_pop    = !q_empty && (!q_entry.emit || out_free);

  assign base     = (q_entry.cmd == symcrc_pkg::CMD_RAW_START) ? symcrc_pkg::CRC_ONES : acc_r;
  assign absorbed = symcrc_pkg::crc_byte(base, q_entry.data);

  always_comb begin
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    res_crc_nxt   = absorbed ^ symcrc_pkg::CRC_ONES;
    res_match_nxt = 1'b0;
    res_kind_nxt  = 1'b0;
    unique case (q_entry.cmd)
      symcrc_pkg::CMD_HDR_OPEN: begin
        acc_nxt = q_entry.crc;
        exp_nxt = q_entry.exp_crc;
      end
      symcrc_pkg::CMD_HDR_DONE: begin
        acc_nxt       = symcrc_pkg::CRC_ONES;
        exp_nxt       = q_entry.exp_crc;
        res_crc_nxt   = q_entry.crc ^ symcrc_pkg::CRC_ONES;
        res_match_nxt = ((q_entry.crc ^ symcrc_pkg::CRC_ONES) == q_entry.exp_crc);
        res_kind_nxt  = 1'b1;
      end
      symcrc_pkg::CMD_SYM_BYTE: begin
        acc_nxt       = q_entry.emit ? symcrc_pkg::CRC_ONES : absorbed;
        res_match_nxt = ((absorbed ^ symcrc_pkg::CRC_ONES) == exp_r);
        res_kind_nxt  = 1'b1;
      end
      symcrc_pkg::CMD_RAW_START, symcrc_pkg::CMD_RAW_BYTE: begin
        acc_nxt = q_entry.emit ? symcrc_pkg::CRC_ONES : absorbed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= symcrc_pkg::CRC_ONES;
      exp_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        acc_r <= acc_nxt;
        exp_r <= exp_nxt;
      end
      if (q_pop && q_entry.emit) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.emit) begin
      res_crc_r   <= res_crc_nxt;
      res_match_r <= res_match_nxt;
      res_kind_r  <= res_kind_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, res_match_r, res_crc_r};
  assign out_tuser  = res_kind_r;

endmodule

`default_nettype wire

@@ hdl/symbol_crc32c_engine.sv @@
// top level of the symbol crc32c engine
//
//   channel  direction  transaction
//   in_      slave      header, payload byte or raw byte (tuser = opcode)
//   out_     master     finished crc with match flag (tuser = result kind)
//   cfg_     write      max_payload_len, one register
//
// one item per cycle sustained while the queue has room; the header crc is a
// combinational xor tree in the front end and each byte takes one pass through
// the back end byte unit. the closing item's result goes through the queue and
// then the out_ output register, which it enters once that register is free.
// synchronous active-low reset, no clearing pass; the block accepts at once.
// in_tready falls only when the four-entry queue fills behind a stalled output.
`default_nettype none

module symbol_crc32c_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [15:0]                         cfg_wr_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // packet id, fec id, symbol number, symbol count, payload length, stored crc,
  // data byte
  input  wire logic [symcrc_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode
  input  wire logic [symcrc_pkg::IN_USER_W-1:0]    in_tuser,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // crc_value, crc_match, zero fill
  output logic [symcrc_pkg::OUT_DATA_W-1:0]        out_tdata,
  // result_kind
  output logic                                     out_tuser
);

  symcrc_pkg::entry_t     push_entry;
  symcrc_pkg::entry_t     head_entry;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_push;
  logic                   q_pop;

  symcrc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  symcrc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (push_entry),
    .pop      (q_pop),
    .rd_entry (head_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  symcrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_entry    (head_entry),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_raw_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> !out_tdata[32])
    else $error("raw result flagged as match");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !(q_pop && head_entry.emit))
    else $error("result popped onto a stalled output");
`endif

endmodule

`default_nettype wire
